// ===== hw/rtl/srlm_pkg.sv =====
`timescale 1ns / 1ps

package srlm_pkg;

  localparam int BUF_FRAMES_DEF = 512;
  localparam int HIST_DEPTH_DEF = 256;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 15;
  localparam int SLOT_W   = 8;
  localparam int WEIGHT_W = 17;

  localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 17'd4588;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE        = 17'h10000;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_frame;
    logic [SLOT_W-1:0]          read_slot;
  } srlm_in_t;

  typedef struct packed {
    logic               is_read_reply;
    logic [LEVEL_W-1:0] level;
    logic [SLOT_W-1:0]  slot;
  } srlm_out_t;

endpackage

// ===== hw/rtl/stereo_rms_level_meter_unit.sv =====
`timescale 1ns / 1ps

// Stereo RMS level meter. Each input word is a stereo sample frame or a
// history read. A frame adds the squares of both samples to a running sum;
// once BUF_FRAMES frames are counted, further frames are dropped. A frame
// marked last closes the buffer: a restoring divider forms the mean square
// one bit per cycle over the sum width, a bit-pair square root follows, and
// two passes through the shared multiplier smooth the level before the new
// volume word is loaded into the output register and written to the history
// ring. A read passes through the registered memory read before its reply
// is loaded into the output register. One shared multiplier serves the
// squares and the smoothing step.
// The input side is stalled whenever the sequencer is busy. The output
// register holds one result word; while the receiver stalls it, the block
// keeps taking frames that give no result and waits only when a new result
// is ready. Reset clears the sum, count, volume, history and write slot and
// restores the smoothing weight to 4588; no clearing pass is needed.
module stereo_rms_level_meter_unit
  import srlm_pkg::*;
#(
  parameter int BUF_FRAMES = BUF_FRAMES_DEF,
  parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srlm_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srlm_out_t           out_data_o
);

  localparam int CNT_W     = $clog2(BUF_FRAMES + 1);
  localparam int SUM_W     = 31 + CNT_W;
  localparam int DIV_W     = CNT_W + 1;
  localparam int QUO_W     = 32;
  localparam int ROOT_W    = 16;
  localparam int REM_W     = ROOT_W + 2;
  localparam int STEP_W    = $clog2(SUM_W + 1);
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 16;
  localparam int PROD_W    = 32;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SQ_L   = 10'b0000000010,
    ST_SQ_R   = 10'b0000000100,
    ST_SQ_ADD = 10'b0000001000,
    ST_DIV    = 10'b0000010000,
    ST_SQRT   = 10'b0000100000,
    ST_MUL_A  = 10'b0001000000,
    ST_MUL_B  = 10'b0010000000,
    ST_EMIT   = 10'b0100000000,
    ST_RD_OUT = 10'b1000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [WEIGHT_W-1:0]    weight_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [LEVEL_W-1:0]     vol_q, vol_d;
  logic [SAMPLE_W-1:0]    abs_l_q, abs_r_q;
  logic                   last_q;
  logic [SLOT_W-1:0]      rd_slot_q;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [DIV_W-1:0]       rem_q, rem_d;
  logic [QUO_W-1:0]       quo_q, quo_d;
  logic [REM_W-1:0]       sr_q, sr_d;
  logic [ROOT_W-1:0]      root_q, root_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  srlm_out_t              out_data_q, out_data_d;

  logic                   in_accept;
  logic                   out_free;
  logic                   count_full;
  logic [SAMPLE_W-1:0]    abs_l, abs_r;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [WEIGHT_W-1:0]    w_sat, w_comp;
  logic [DIV_W-1:0]       divisor;
  logic [DIV_W:0]         rem_sh;
  logic [REM_W+1:0]       sr_sh, trial;
  logic [PROD_W-1:0]      acc;
  logic                   hist_wr_en;
  logic                   hist_rd_en;
  logic [SLOT_W-1:0]      hist_wr_slot;
  logic [LEVEL_W-1:0]     hist_rd_level;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign count_full = (count_q == CNT_W'(BUF_FRAMES));

  assign abs_l = in_data_i.left_sample[SAMPLE_W-1]
               ? (~in_data_i.left_sample + SAMPLE_W'(1)) : in_data_i.left_sample;
  assign abs_r = in_data_i.right_sample[SAMPLE_W-1]
               ? (~in_data_i.right_sample + SAMPLE_W'(1)) : in_data_i.right_sample;

  assign w_sat  = weight_q[WEIGHT_W-1] ? WEIGHT_ONE : weight_q;
  assign w_comp = WEIGHT_ONE - w_sat;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ_L: begin
        mul_a = MUL_A_W'(abs_l_q);
        mul_b = abs_l_q;
      end
      ST_SQ_R: begin
        mul_a = MUL_A_W'(abs_r_q);
        mul_b = abs_r_q;
      end
      ST_MUL_A: begin
        mul_a = w_comp;
        mul_b = MUL_B_W'(vol_q);
      end
      ST_MUL_B: begin
        mul_a = w_sat;
        mul_b = MUL_B_W'(root_q[ROOT_W-1:1]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign acc   = prod_q + mul_p;

  assign divisor = {count_q, 1'b0};
  assign rem_sh  = {rem_q, sum_q[SUM_W-1]};
  assign sr_sh   = {sr_q, quo_q[QUO_W-1 -: 2]};
  assign trial   = (REM_W+2)'({root_q, 2'b01});

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    vol_d       = vol_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    sr_d        = sr_q;
    root_d      = root_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    hist_wr_en  = 1'b0;
    hist_rd_en  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.command == CMD_READ) begin
            hist_rd_en = 1'b1;
            state_d    = ST_RD_OUT;
          end else if (!count_full) begin
            count_d = count_q + CNT_W'(1);
            state_d = ST_SQ_L;
          end else if (in_data_i.last_frame) begin
            rem_d   = '0;
            quo_d   = '0;
            step_d  = STEP_W'(SUM_W - 1);
            state_d = ST_DIV;
          end
        end
      end
      ST_SQ_L: begin
        prod_d  = mul_p;
        state_d = ST_SQ_R;
      end
      ST_SQ_R: begin
        sum_d   = sum_q + SUM_W'(prod_q);
        prod_d  = mul_p;
        state_d = ST_SQ_ADD;
      end
      ST_SQ_ADD: begin
        sum_d = sum_q + SUM_W'(prod_q);
        if (last_q) begin
          rem_d   = '0;
          quo_d   = '0;
          step_d  = STEP_W'(SUM_W - 1);
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        sum_d = sum_q << 1;
        if (rem_sh >= (DIV_W+1)'(divisor)) begin
          rem_d = DIV_W'(rem_sh - (DIV_W+1)'(divisor));
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = DIV_W'(rem_sh);
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          sr_d    = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W - 1);
          state_d = ST_SQRT;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_SQRT: begin
        quo_d = quo_q << 2;
        if (sr_sh >= trial) begin
          sr_d   = REM_W'(sr_sh - trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          sr_d   = REM_W'(sr_sh);
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = ST_MUL_A;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_MUL_A: begin
        prod_d  = mul_p;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        vol_d   = acc[16 +: LEVEL_W];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          hist_wr_en               = 1'b1;
          out_valid_d              = 1'b1;
          out_data_d.is_read_reply = 1'b0;
          out_data_d.level         = vol_q;
          out_data_d.slot          = hist_wr_slot;
          count_d                  = '0;
          sum_d                    = '0;
          state_d                  = ST_IDLE;
        end
      end
      ST_RD_OUT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.is_read_reply = 1'b1;
          out_data_d.level         = hist_rd_level;
          out_data_d.slot          = rd_slot_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      weight_q    <= SMOOTH_WEIGHT_RST;
      sum_q       <= '0;
      count_q     <= '0;
      vol_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      vol_q       <= vol_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    sr_q       <= sr_d;
    root_q     <= root_d;
    out_data_q <= out_data_d;
    if (in_accept) begin
      abs_l_q   <= abs_l;
      abs_r_q   <= abs_r;
      last_q    <= in_data_i.last_frame;
      rd_slot_q <= in_data_i.read_slot;
    end
  end

  srlm_history #(
    .HIST_DEPTH(HIST_DEPTH)
  ) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (hist_wr_en),
    .wr_level_i (vol_q),
    .wr_slot_o  (hist_wr_slot),
    .rd_en_i    (hist_rd_en),
    .rd_slot_i  (in_data_i.read_slot),
    .rd_level_o (hist_rd_level)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/srlm_history.sv =====
`timescale 1ns / 1ps

module srlm_history
  import srlm_pkg::*;
#(
  parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [LEVEL_W-1:0] wr_level_i,
  output logic [SLOT_W-1:0]  wr_slot_o,
  input  logic               rd_en_i,
  input  logic [SLOT_W-1:0]  rd_slot_i,
  output logic [LEVEL_W-1:0] rd_level_o
);

  localparam int HIST_AW = $clog2(HIST_DEPTH);

  logic [LEVEL_W-1:0] mem [HIST_DEPTH];
  logic [HIST_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic               wrapped_q, wrapped_d;
  logic [LEVEL_W-1:0] rd_data_q;
  logic               rd_hit_q;
  logic [HIST_AW-1:0] rd_addr;
  logic               rd_in_range;
  logic               rd_hit;

  // Entries are written in ring order from slot zero, so an entry holds data
  // once it lies below the write pointer or the ring has wrapped.
  assign rd_addr     = HIST_AW'(rd_slot_i);
  assign rd_in_range = {24'd0, rd_slot_i} < 32'(HIST_DEPTH);
  assign rd_hit      = rd_in_range && (wrapped_q || (rd_addr < wr_ptr_q));

  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    wrapped_d = wrapped_q;
    if (wr_en_i) begin
      if (wr_ptr_q == HIST_AW'(HIST_DEPTH - 1)) begin
        wr_ptr_d  = '0;
        wrapped_d = 1'b1;
      end else begin
        wr_ptr_d = wr_ptr_q + HIST_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      wrapped_q <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      wrapped_q <= wrapped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ptr_q] <= wr_level_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
      rd_hit_q  <= rd_hit;
    end
  end

  assign wr_slot_o  = SLOT_W'(wr_ptr_q);
  assign rd_level_o = rd_hit_q ? rd_data_q : '0;

endmodule
